@@ sv/lmsd_pkg.sv @@
`timescale 1ns / 1ps

package lmsd_pkg;

  localparam int DEVICE_COUNT = 2;
  localparam int STORE_LEN    = DEVICE_COUNT * 8;
  localparam int STORE_W      = $clog2(STORE_LEN);
  localparam int DEV_W        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(DEVICE_COUNT - 1);

  localparam int BRIGHT_W = 4;
  localparam int SCAN_W   = 3;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 1'b1;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_GLYPH = 2'd1;
  localparam logic [1:0] CMD_BLANK = 2'd2;
  localparam logic [1:0] CMD_OFF   = 2'd3;

  localparam logic [3:0] REG_NOOP      = 4'h0;
  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN      = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;

  localparam logic [7:0] FONT_FIRST = 8'd32;
  localparam logic [7:0] FONT_END   = 8'd127;
  localparam logic [2:0] FONT_W     = 3'd5;

  // micro-ops
  localparam logic [1:0] OP_BCAST   = 2'd0;
  localparam logic [1:0] OP_ROWS    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;
  localparam logic [1:0] OP_SHIFT   = 2'd3;

  // data sources
  localparam logic [2:0] D_BRIGHT = 3'd0;
  localparam logic [2:0] D_SCAN   = 3'd1;
  localparam logic [2:0] D_ZERO   = 3'd2;
  localparam logic [2:0] D_ONE    = 3'd3;
  localparam logic [2:0] D_STORE  = 3'd4;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ENTRY_INIT  = 4'd0;
  localparam logic [STEP_W-1:0] ENTRY_GLYPH = 4'd6;
  localparam logic [STEP_W-1:0] STEP_REFRESH = 4'd7;
  localparam logic [STEP_W-1:0] ENTRY_BLANK = 4'd8;
  localparam logic [STEP_W-1:0] ENTRY_OFF   = 4'd9;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        addr;
    logic [2:0]        dsel;
    logic              shift_zero;
    logic              clr;
    logic              fin;
    logic [STEP_W-1:0] nxt;
  } ucode_t;

  typedef struct packed {
    logic             exec;
    logic [1:0]       op;
    logic [3:0]       addr;
    logic [2:0]       dsel;
    logic             shift_zero;
    logic             clr;
    logic             done;
    logic             last;
    logic [DEV_W-1:0] k;
    logic [2:0]       row;
    logic [DEV_W-1:0] dev;
  } ctrl_t;

  function automatic ucode_t uc_word(input logic [1:0] op, input logic [3:0] addr,
                                     input logic [2:0] dsel, input logic shift_zero,
                                     input logic clr, input logic fin,
                                     input logic [STEP_W-1:0] nxt);
    ucode_t w;
    w.op = op;
    w.addr = addr;
    w.dsel = dsel;
    w.shift_zero = shift_zero;
    w.clr = clr;
    w.fin = fin;
    w.nxt = nxt;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      4'd0:    w = uc_word(OP_BCAST, REG_INTENSITY, D_BRIGHT, 1'b0, 1'b0, 1'b0, 4'd1);
      4'd1:    w = uc_word(OP_BCAST, REG_DECODE, D_ZERO, 1'b0, 1'b0, 1'b0, 4'd2);
      4'd2:    w = uc_word(OP_BCAST, REG_SCAN, D_SCAN, 1'b0, 1'b0, 1'b0, 4'd3);
      4'd3:    w = uc_word(OP_BCAST, REG_SHUTDOWN, D_ONE, 1'b0, 1'b0, 1'b0, 4'd4);
      4'd4:    w = uc_word(OP_BCAST, REG_TEST, D_ZERO, 1'b0, 1'b0, 1'b0, 4'd5);
      4'd5:    w = uc_word(OP_ROWS, REG_NOOP, D_ZERO, 1'b0, 1'b1, 1'b1, 4'd0);
      4'd6:    w = uc_word(OP_SHIFT, REG_NOOP, D_ZERO, 1'b0, 1'b0, 1'b0, STEP_REFRESH);
      4'd7:    w = uc_word(OP_REFRESH, REG_NOOP, D_STORE, 1'b0, 1'b0, 1'b1, 4'd0);
      4'd8:    w = uc_word(OP_SHIFT, REG_NOOP, D_ZERO, 1'b1, 1'b0, 1'b0, STEP_REFRESH);
      4'd9:    w = uc_word(OP_BCAST, REG_SHUTDOWN, D_ZERO, 1'b0, 1'b0, 1'b1, 4'd0);
      default: w = uc_word(OP_SHIFT, REG_NOOP, D_ZERO, 1'b1, 1'b0, 1'b1, 4'd0);
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] entry_of(input logic [1:0] cmd);
    logic [STEP_W-1:0] e;
    case (cmd)
      CMD_INIT:  e = ENTRY_INIT;
      CMD_GLYPH: e = ENTRY_GLYPH;
      CMD_BLANK: e = ENTRY_BLANK;
      CMD_OFF:   e = ENTRY_OFF;
      default:   e = ENTRY_OFF;
    endcase
    return e;
  endfunction

  // columns 0..4 from most significant byte down
  function automatic logic [39:0] font_bits(input logic [6:0] idx);
    logic [39:0] b;
    case (idx)
      7'd0:  b = 40'h0000000000;  7'd1:  b = 40'h00004F0000;  7'd2:  b = 40'h0007000700;
      7'd3:  b = 40'h147F147F14;  7'd4:  b = 40'h242A7F2A12;  7'd5:  b = 40'h2313086462;
      7'd6:  b = 40'h3649552250;  7'd7:  b = 40'h0005030000;  7'd8:  b = 40'h001C224100;
      7'd9:  b = 40'h0041221C00;  7'd10: b = 40'h14083E0814;  7'd11: b = 40'h08083E0808;
      7'd12: b = 40'h0050300000;  7'd13: b = 40'h0008080808;  7'd14: b = 40'h0060600000;
      7'd15: b = 40'h2010080402;  7'd16: b = 40'h3E5149453E;  7'd17: b = 40'h00427F4000;
      7'd18: b = 40'h4261514946;  7'd19: b = 40'h2141454B31;  7'd20: b = 40'h1814127F10;
      7'd21: b = 40'h2745454539;  7'd22: b = 40'h3C4A494930;  7'd23: b = 40'h0371090503;
      7'd24: b = 40'h3649494936;  7'd25: b = 40'h064949291E;  7'd26: b = 40'h006C6C0000;
      7'd27: b = 40'h0056360000;  7'd28: b = 40'h0814224100;  7'd29: b = 40'h1414141414;
      7'd30: b = 40'h0041221408;  7'd31: b = 40'h0201510906;  7'd32: b = 40'h324979413E;
      7'd33: b = 40'h7E1111117E;  7'd34: b = 40'h7F4949493E;  7'd35: b = 40'h3E41414122;
      7'd36: b = 40'h7F4141413E;  7'd37: b = 40'h7F49494949;  7'd38: b = 40'h7F09090901;
      7'd39: b = 40'h3E4149493A;  7'd40: b = 40'h7F0808087F;  7'd41: b = 40'h41417F4141;
      7'd42: b = 40'h3041413F01;  7'd43: b = 40'h7F08142241;  7'd44: b = 40'h7F40404040;
      7'd45: b = 40'h7F020C027F;  7'd46: b = 40'h7F0408107F;  7'd47: b = 40'h3E4141413E;
      7'd48: b = 40'h7F09090906;  7'd49: b = 40'h3E4151215E;  7'd50: b = 40'h7F09091966;
      7'd51: b = 40'h4649494931;  7'd52: b = 40'h01017F0101;  7'd53: b = 40'h3F4040403F;
      7'd54: b = 40'h0F3040300F;  7'd55: b = 40'h3F4038403F;  7'd56: b = 40'h6314081463;
      7'd57: b = 40'h0304780403;  7'd58: b = 40'h6151494543;  7'd59: b = 40'h7F41410000;
      7'd60: b = 40'h0204081020;  7'd61: b = 40'h000041417F;  7'd62: b = 40'h0402010204;
      7'd63: b = 40'h4040404040;  7'd64: b = 40'h0001020400;  7'd65: b = 40'h2054545478;
      7'd66: b = 40'h7F48444438;  7'd67: b = 40'h3844444420;  7'd68: b = 40'h384444487F;
      7'd69: b = 40'h3854545418;  7'd70: b = 40'h087E090102;  7'd71: b = 40'h0C5252523E;
      7'd72: b = 40'h7F08040478;  7'd73: b = 40'h00447D4000;  7'd74: b = 40'h2040443D00;
      7'd75: b = 40'h7F10284400;  7'd76: b = 40'h00417F4000;  7'd77: b = 40'h7804080478;
      7'd78: b = 40'h7C08040478;  7'd79: b = 40'h3844444438;  7'd80: b = 40'h7C14141408;
      7'd81: b = 40'h0814147C00;  7'd82: b = 40'h7C08040408;  7'd83: b = 40'h4854545420;
      7'd84: b = 40'h043F444020;  7'd85: b = 40'h3C4040207C;  7'd86: b = 40'h1C2040201C;
      7'd87: b = 40'h3C4030403C;  7'd88: b = 40'h4428102844;  7'd89: b = 40'h0C5050503C;
      7'd90: b = 40'h4464544C44;  7'd91: b = 40'h0008364100;  7'd92: b = 40'h00007F0000;
      7'd93: b = 40'h0041360800;  7'd94: b = 40'h0804040804;
      default: b = 40'h0000000000;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0]  off;
    logic [39:0] bits;
    logic [7:0]  res;
    int          sh;
    off  = code - FONT_FIRST;
    bits = font_bits(off[6:0]);
    res  = 8'h00;
    sh   = 0;
    if (code >= FONT_FIRST && code < FONT_END && col < FONT_W) begin
      sh  = 8 * (4 - int'(col));
      res = bits[sh +: 8];
    end
    return res;
  endfunction

endpackage

@@ sv/lmsd_in_if.sv @@
`timescale 1ns / 1ps

interface lmsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [2:0] glyph_column;

  modport source (output valid, command, char_code, glyph_column, input ready);
  modport sink   (input valid, command, char_code, glyph_column, output ready);
endinterface

@@ sv/lmsd_out_if.sv @@
`timescale 1ns / 1ps

interface lmsd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       frame_end;
  logic       last;

  modport source (output valid, reg_addr, reg_data, frame_end, last, input ready);
  modport sink   (input valid, reg_addr, reg_data, frame_end, last, output ready);
endinterface

@@ sv/led_matrix_scroll_driver_top.sv @@
`timescale 1ns / 1ps
// channel   dir   payload                                    beat
// in_ch     sink  command, char_code, glyph_column           valid & ready
// out_ch    src   reg_addr, reg_data, frame_end, last        valid & ready
// cfg       in    cfg_we, cfg_index, cfg_data                cfg_we
//
// One beat in, then one driver word out per cycle from the microcode program.
// Initialize: 13*DEVICE_COUNT words; glyph/blank push: one shift step plus
// 8*DEVICE_COUNT*DEVICE_COUNT refresh words; off: DEVICE_COUNT words.
// A new command is taken once the program has issued its last word.
// Output stall freezes the sequencer; synchronous reset clears the column store.

module led_matrix_scroll_driver_top (
  input  logic                                 clk,
  input  logic                                 rst,
  lmsd_in_if.sink                              in_ch,
  lmsd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [lmsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lmsd_pkg::CFG_W-1:0]           cfg_data
);

  logic [lmsd_pkg::BRIGHT_W-1:0] brightness;
  logic [lmsd_pkg::SCAN_W-1:0]   row_scan_limit;
  logic                          busy;
  logic                          start;
  logic                          adv;
  lmsd_pkg::ctrl_t               ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= 4'd15;
      row_scan_limit <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        lmsd_pkg::CFG_BRIGHTNESS: brightness     <= cfg_data[lmsd_pkg::BRIGHT_W-1:0];
        lmsd_pkg::CFG_SCAN_LIMIT: row_scan_limit <= cfg_data[lmsd_pkg::SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && !busy;

  lmsd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (in_ch.command),
    .adv   (adv),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  lmsd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .start          (start),
    .char_code      (in_ch.char_code),
    .glyph_column   (in_ch.glyph_column),
    .brightness     (brightness),
    .row_scan_limit (row_scan_limit),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .reg_addr       (out_ch.reg_addr),
    .reg_data       (out_ch.reg_data),
    .frame_end      (out_ch.frame_end),
    .last           (out_ch.last),
    .adv            (adv)
  );

endmodule

@@ sv/lmsd_seq.sv @@
`timescale 1ns / 1ps

module lmsd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          cmd,
  input  logic                adv,
  output logic                busy,
  output lmsd_pkg::ctrl_t     ctrl
);

  logic [lmsd_pkg::STEP_W-1:0] step;
  logic [lmsd_pkg::DEV_W-1:0]  k;
  logic [lmsd_pkg::DEV_W-1:0]  dev;
  logic [2:0]                  row;
  lmsd_pkg::ucode_t            uc;
  logic                        k_max;
  logic                        row_max;
  logic                        dev_max;
  logic                        done;
  logic                        exec;

  assign uc      = lmsd_pkg::ucode_rom(step);
  assign k_max   = (k == lmsd_pkg::DEV_LAST);
  assign row_max = (row == 3'd7);
  assign dev_max = (dev == lmsd_pkg::DEV_LAST);
  assign exec    = busy && adv;

  always_comb begin
    case (uc.op)
      lmsd_pkg::OP_BCAST:   done = k_max;
      lmsd_pkg::OP_ROWS:    done = k_max && row_max;
      lmsd_pkg::OP_REFRESH: done = k_max && row_max && dev_max;
      default:              done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= lmsd_pkg::ENTRY_INIT;
      k    <= '0;
      row  <= '0;
      dev  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= lmsd_pkg::entry_of(cmd);
    end else if (exec) begin
      if (done) begin
        k   <= '0;
        row <= '0;
        dev <= '0;
        if (uc.fin) begin
          busy <= 1'b0;
        end else begin
          step <= uc.nxt;
        end
      end else if (k_max) begin
        k <= '0;
        if (row_max) begin
          row <= '0;
          dev <= lmsd_pkg::DEV_W'(dev + 1'b1);
        end else begin
          row <= row + 3'd1;
        end
      end else begin
        k <= lmsd_pkg::DEV_W'(k + 1'b1);
      end
    end
  end

  always_comb begin
    ctrl.exec       = exec;
    ctrl.op         = uc.op;
    ctrl.addr       = uc.addr;
    ctrl.dsel       = uc.dsel;
    ctrl.shift_zero = uc.shift_zero;
    ctrl.clr        = uc.clr;
    ctrl.done       = done;
    ctrl.last       = uc.fin && done;
    ctrl.k          = k;
    ctrl.row        = row;
    ctrl.dev        = dev;
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec && ctrl.last |=> !busy)
    else $error("sequencer still busy after last beat");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (k == '0) && (row == 3'd0) && (dev == '0))
    else $error("loop counters not at rest while idle");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !(exec && ctrl.last) |=> busy)
    else $error("sequencer left program without last beat");

endmodule

@@ sv/lmsd_dp.sv @@
`timescale 1ns / 1ps

module lmsd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  lmsd_pkg::ctrl_t                     ctrl,
  input  logic                                start,
  input  logic [7:0]                          char_code,
  input  logic [2:0]                          glyph_column,
  input  logic [lmsd_pkg::BRIGHT_W-1:0]       brightness,
  input  logic [lmsd_pkg::SCAN_W-1:0]         row_scan_limit,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [3:0]                          reg_addr,
  output logic [7:0]                          reg_data,
  output logic                                frame_end,
  output logic                                last,
  output logic                                adv
);

  logic [7:0] store [lmsd_pkg::STORE_LEN];
  logic [7:0] glyph;
  logic       sel;
  logic       emit;
  logic [3:0] row_addr;
  logic [3:0] addr_next;
  logic [7:0] data_next;
  logic [lmsd_pkg::STORE_W-1:0] rd_idx;

  assign adv      = !out_valid || out_ready;
  assign sel      = (ctrl.k == ctrl.dev);
  assign emit     = ctrl.exec && (ctrl.op != lmsd_pkg::OP_SHIFT);
  assign row_addr = {1'b0, ctrl.row} + 4'd1;
  assign rd_idx   = lmsd_pkg::STORE_W'({ctrl.dev, ctrl.row});

  always_comb begin
    case (ctrl.op)
      lmsd_pkg::OP_BCAST:   addr_next = ctrl.addr;
      lmsd_pkg::OP_ROWS:    addr_next = row_addr;
      lmsd_pkg::OP_REFRESH: addr_next = sel ? row_addr : lmsd_pkg::REG_NOOP;
      default:              addr_next = lmsd_pkg::REG_NOOP;
    endcase
    case (ctrl.dsel)
      lmsd_pkg::D_BRIGHT: data_next = 8'(brightness);
      lmsd_pkg::D_SCAN:   data_next = 8'(row_scan_limit);
      lmsd_pkg::D_ONE:    data_next = 8'd1;
      lmsd_pkg::D_STORE:  data_next = sel ? store[rd_idx] : 8'd0;
      default:            data_next = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      glyph <= lmsd_pkg::glyph_col(char_code, glyph_column);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lmsd_pkg::STORE_LEN; i++) begin
        store[i] <= 8'd0;
      end
    end else if (ctrl.exec) begin
      if (ctrl.op == lmsd_pkg::OP_SHIFT) begin
        for (int i = 0; i < lmsd_pkg::STORE_LEN - 1; i++) begin
          store[i] <= store[i+1];
        end
        store[lmsd_pkg::STORE_LEN-1] <= ctrl.shift_zero ? 8'd0 : glyph;
      end else if (ctrl.clr && ctrl.done) begin
        for (int i = 0; i < lmsd_pkg::STORE_LEN; i++) begin
          store[i] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      reg_addr  <= addr_next;
      reg_data  <= data_next;
      frame_end <= (ctrl.k == lmsd_pkg::DEV_LAST);
      last      <= ctrl.last;
    end
  end

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || out_ready)
    else $error("beat issued over an untaken beat");

endmodule

@@ tb/led_matrix_scroll_driver_top_tb.sv @@
`timescale 1ns / 1ps

module led_matrix_scroll_driver_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 33;
  localparam int MAX_PRINTS     = 40;

  typedef struct {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [2:0] glyph_column;
  } scroll_cmd_t;

  typedef struct {
    logic [3:0] addr;
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } driver_word_t;

  // five font columns per glyph, column 0 in the top byte
  localparam logic [39:0] GLYPH_FONT [95] = '{
    40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0008080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0371090503, 40'h3649494936,
    40'h064949291E, 40'h006C6C0000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F4949493E,
    40'h3E41414122, 40'h7F4141413E, 40'h7F49494949, 40'h7F09090901, 40'h3E4149493A,
    40'h7F0808087F, 40'h41417F4141, 40'h3041413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09091966, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h0F3040300F,
    40'h3F4038403F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h7F41410000,
    40'h0204081020, 40'h000041417F, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7804080478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h0814147C00, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804040804
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lmsd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lmsd_pkg::CFG_W-1:0] cfg_data;

  lmsd_in_if  in_ch ();
  lmsd_out_if out_ch ();

  led_matrix_scroll_driver_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scroll_cmd_t  pending_cmds [$];
  driver_word_t expected_words [$];

  logic [7:0] col_store [lmsd_pkg::STORE_LEN];
  logic [3:0] brightness_q;
  logic [2:0] scan_limit_q;

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;
  logic in_beat;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_word(input logic [3:0] addr, input logic [7:0] data,
                           input logic frame_end);
    driver_word_t w;
    w.addr      = addr;
    w.data      = data;
    w.frame_end = frame_end;
    w.last      = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic push_frame(input logic [3:0] addr, input logic [7:0] data);
    for (int d = 0; d < lmsd_pkg::DEVICE_COUNT; d++)
      push_word(addr, data, d == lmsd_pkg::DEVICE_COUNT - 1);
  endtask

  function automatic logic [7:0] font_column(input logic [7:0] code, input logic [2:0] col);
    logic [39:0] bits;
    if (code < lmsd_pkg::FONT_FIRST || code >= lmsd_pkg::FONT_END || col >= lmsd_pkg::FONT_W)
      return 8'h00;
    bits = GLYPH_FONT[code - lmsd_pkg::FONT_FIRST];
    return bits[8 * (4 - col) +: 8];
  endfunction

  // scroll the store one column and repaint every row of every device
  task automatic scroll_and_refresh(input logic [7:0] new_col);
    for (int i = 0; i < lmsd_pkg::STORE_LEN - 1; i++) col_store[i] = col_store[i + 1];
    col_store[lmsd_pkg::STORE_LEN - 1] = new_col;
    for (int dev = 0; dev < lmsd_pkg::DEVICE_COUNT; dev++)
      for (int row = 0; row < 8; row++)
        for (int k = 0; k < lmsd_pkg::DEVICE_COUNT; k++)
          if (k == dev)
            push_word(4'(row + 1), col_store[row + 8 * dev], k == lmsd_pkg::DEVICE_COUNT - 1);
          else
            push_word(lmsd_pkg::REG_NOOP, 8'h00, k == lmsd_pkg::DEVICE_COUNT - 1);
  endtask

  task automatic predict_words(input scroll_cmd_t c);
    case (c.command)
      lmsd_pkg::CMD_INIT: begin
        push_frame(lmsd_pkg::REG_INTENSITY, {4'h0, brightness_q});
        push_frame(lmsd_pkg::REG_DECODE, 8'h00);
        push_frame(lmsd_pkg::REG_SCAN, {5'h00, scan_limit_q});
        push_frame(lmsd_pkg::REG_SHUTDOWN, 8'h01);
        push_frame(lmsd_pkg::REG_TEST, 8'h00);
        for (int r = 0; r < 8; r++) push_frame(4'(r + 1), 8'h00);
        for (int i = 0; i < lmsd_pkg::STORE_LEN; i++) col_store[i] = 8'h00;
      end
      lmsd_pkg::CMD_GLYPH: scroll_and_refresh(font_column(c.char_code, c.glyph_column));
      lmsd_pkg::CMD_BLANK: scroll_and_refresh(8'h00);
      default: push_frame(lmsd_pkg::REG_SHUTDOWN, 8'h00);
    endcase
    expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  task automatic queue_cmd(input logic [1:0] command, input logic [7:0] code,
                           input logic [2:0] col);
    scroll_cmd_t c;
    c.command      = command;
    c.char_code    = code;
    c.glyph_column = col;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random_cmd();
    int pick;
    logic [1:0] command;
    logic [7:0] code;
    logic [2:0] col;
    pick = $urandom_range(99);
    if (pick < 8) command = lmsd_pkg::CMD_INIT;
    else if (pick < 18) command = lmsd_pkg::CMD_OFF;
    else if (pick < 32) command = lmsd_pkg::CMD_BLANK;
    else command = lmsd_pkg::CMD_GLYPH;
    code = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
    col  = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    queue_cmd(command, code, col);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] bright, input logic [2:0] scan);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lmsd_pkg::CFG_BRIGHTNESS;
    cfg_data  <= bright;
    @(negedge clk);
    cfg_index <= lmsd_pkg::CFG_SCAN_LIMIT;
    cfg_data  <= {1'b0, scan};
    @(negedge clk);
    cfg_we    <= 1'b0;
    brightness_q = bright;
    scan_limit_q = scan;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    scroll_cmd_t c;
    if (!rst) begin
      if (!in_ch.valid || in_beat) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.command      <= c.command;
          in_ch.char_code    <= c.char_code;
          in_ch.glyph_column <= c.glyph_column;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    scroll_cmd_t  c;
    driver_word_t want;
    in_beat <= in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        c.command      = in_ch.command;
        c.char_code    = in_ch.char_code;
        c.glyph_column = in_ch.glyph_column;
        predict_words(c);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word addr=%h data=%h fe=%b last=%b",
                                    out_ch.reg_addr, out_ch.reg_data,
                                    out_ch.frame_end, out_ch.last));
        end else begin
          want = expected_words.pop_front();
          if (out_ch.reg_addr !== want.addr)
            report_mismatch($sformatf("reg_addr %h, expected %h", out_ch.reg_addr, want.addr));
          if (out_ch.reg_data !== want.data)
            report_mismatch($sformatf("reg_data %h, expected %h (addr %h)",
                                      out_ch.reg_data, want.data, want.addr));
          if (out_ch.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      out_ch.frame_end, want.frame_end));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_ch.last, want.last));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = lmsd_pkg::CFG_BRIGHTNESS;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = lmsd_pkg::CMD_INIT;
    in_ch.char_code    = 8'h00;
    in_ch.glyph_column = 3'd0;
    out_ch.ready       = 1'b0;
    in_beat            = 1'b0;
    error_count        = 0;
    idle_cycles        = 0;
    send_idle_pct      = 12;
    recv_idle_pct      = 47;
    brightness_q       = 4'd15;
    scan_limit_q       = 3'd7;
    for (int i = 0; i < lmsd_pkg::STORE_LEN; i++) col_store[i] = 8'h00;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, font edges, unmapped codes, bad columns
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd65, 3'd0);
    queue_cmd(lmsd_pkg::CMD_INIT, 8'hFF, 3'd7);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd32, 3'd0);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd33, 3'd2);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd126, 3'd4);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd127, 3'd2);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd31, 3'd1);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd0, 3'd0);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd255, 3'd7);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd128, 3'd3);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd87, 3'd5);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd87, 3'd6);
    for (int k = 0; k < 5; k++) queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd72, 3'(k));
    queue_cmd(lmsd_pkg::CMD_BLANK, 8'h5A, 3'd3);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd64, 3'd4);
    queue_cmd(lmsd_pkg::CMD_OFF, 8'hA5, 3'd5);
    queue_cmd(lmsd_pkg::CMD_GLYPH, 8'd56, 3'd1);
    queue_cmd(lmsd_pkg::CMD_INIT, 8'h00, 3'd0);
    queue_cmd(lmsd_pkg::CMD_OFF, 8'h00, 3'd0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 12;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) write_config(4'd0, 3'd0);
      else if (p == 1) write_config(4'd15, 3'd7);
      else write_config(4'($urandom_range(15)), 3'($urandom_range(7)));
      queue_cmd(lmsd_pkg::CMD_INIT, 8'($urandom_range(255)), 3'($urandom_range(7)));
      for (int n = 0; n < PHASE_ITEMS - 1; n++) queue_random_cmd();
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
